// File: rtl/complex_arithmetic_unit_assert.svh
// Assertion macros for the complex arithmetic unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Checks an implication in the same cycle.
`define CAU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cau assertion failed");

// Checks an implication in the next cycle.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cau assertion failed");

`endif

// File: rtl/cau_pkg.sv
// Shared types, widths and the saturation function of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = 2 * DATA_WIDTH + 1;
    localparam int MAG_W      = 2 * DATA_WIDTH;
    localparam int DEN_W      = 2 * DATA_WIDTH;
    localparam int NUM_W      = MAG_W + FRAC_BITS;
    localparam int Q_W        = DATA_WIDTH + 1;
    localparam int STEP_W     = $clog2(Q_W);
    localparam int CMP_W      = DEN_W + Q_W;

    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (DATA_WIDTH - 1));

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        action_t          action;
        lane_t            re;
        lane_t            im;
        logic [DEN_W-1:0] den;
    } item_t;

    typedef struct packed {
        logic                  sat;
        logic [DATA_WIDTH-1:0] val;
    } clamp_t;

    function automatic clamp_t clamp_mag(logic neg, logic [MAG_W-1:0] mag, logic big);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        clamp_t           r;
        lim   = neg ? NEG_LIM : POS_LIM;
        r.sat = big || (mag > lim);
        m     = r.sat ? lim : mag;
        r.val = neg ? DATA_WIDTH'(MAG_W'(0) - m) : DATA_WIDTH'(m);
        return r;
    endfunction

endpackage

// File: rtl/cau_prod.sv
// Front end of the complex arithmetic unit: products, sums and divider setup.
// Depends on cau_pkg.
module cau_prod (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic [1:0]                          action,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] left_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] left_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] right_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] right_imag,
    output logic                                out_valid,
    output cau_pkg::item_t                      out_item
);
    import cau_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    action_t                  act1_reg, act2_reg;
    logic signed [DATA_WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [PROD_W-1:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [SUM_W-1:0]  re_s_next, im_s_next, re_s_reg, im_s_reg;
    logic [DEN_W-1:0]         den_next, den_reg;
    item_t                    item_next, item_reg;
    logic [MAG_W-1:0]         re_mag, im_mag;
    logic [CMP_W-1:0]         lim_cmp;

    always_comb
    begin
        unique case (act1_reg)
            ACT_ADD:
            begin
                re_s_next = SUM_W'(a_reg) + SUM_W'(c_reg);
                im_s_next = SUM_W'(b_reg) + SUM_W'(d_reg);
            end
            ACT_SUB:
            begin
                re_s_next = SUM_W'(a_reg) - SUM_W'(c_reg);
                im_s_next = SUM_W'(b_reg) - SUM_W'(d_reg);
            end
            ACT_MUL:
            begin
                re_s_next = SUM_W'(ac_reg) - SUM_W'(bd_reg);
                im_s_next = SUM_W'(ad_reg) + SUM_W'(bc_reg);
            end
            default:
            begin
                re_s_next = SUM_W'(ac_reg) + SUM_W'(bd_reg);
                im_s_next = SUM_W'(bc_reg) - SUM_W'(ad_reg);
            end
        endcase
        den_next = DEN_W'(cc_reg) + DEN_W'(dd_reg);
    end

    always_comb
    begin
        re_mag  = re_s_reg[SUM_W-1] ? MAG_W'(-re_s_reg) : MAG_W'(re_s_reg);
        im_mag  = im_s_reg[SUM_W-1] ? MAG_W'(-im_s_reg) : MAG_W'(im_s_reg);
        lim_cmp = CMP_W'(den_reg) << Q_W;
        item_next.action = act2_reg;
        item_next.den    = den_reg;
        item_next.re.neg = re_s_reg[SUM_W-1];
        item_next.re.mag = re_mag;
        item_next.re.rem = {re_mag, FRAC_BITS'(0)};
        item_next.re.q   = '0;
        item_next.re.ovf = CMP_W'({re_mag, FRAC_BITS'(0)}) >= lim_cmp;
        item_next.im.neg = im_s_reg[SUM_W-1];
        item_next.im.mag = im_mag;
        item_next.im.rem = {im_mag, FRAC_BITS'(0)};
        item_next.im.q   = '0;
        item_next.im.ovf = CMP_W'({im_mag, FRAC_BITS'(0)}) >= lim_cmp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            act1_reg <= action_t'(action);
            a_reg    <= left_real;
            b_reg    <= left_imag;
            c_reg    <= right_real;
            d_reg    <= right_imag;
            ac_reg   <= left_real * right_real;
            bd_reg   <= left_imag * right_imag;
            ad_reg   <= left_real * right_imag;
            bc_reg   <= left_imag * right_real;
            cc_reg   <= right_real * right_real;
            dd_reg   <= right_imag * right_imag;
            act2_reg <= act1_reg;
            re_s_reg <= re_s_next;
            im_s_reg <= im_s_next;
            den_reg  <= den_next;
            item_reg <= item_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/cau_div_step.sv
// One restoring division stage producing one quotient bit per lane.
// Depends on cau_pkg.
module cau_div_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [cau_pkg::STEP_W-1:0]  step,
    input  logic                        in_valid,
    input  cau_pkg::item_t              in_item,
    output logic                        out_valid,
    output cau_pkg::item_t              out_item
);
    import cau_pkg::*;

    logic             valid_reg;
    item_t            item_reg, item_next;
    logic [CMP_W-1:0] sh;
    logic [CMP_W-1:0] re_r, im_r;

    always_comb
    begin
        item_next = in_item;
        sh   = CMP_W'(in_item.den) << step;
        re_r = CMP_W'(in_item.re.rem);
        im_r = CMP_W'(in_item.im.rem);
        if (in_item.action == ACT_DIV)
        begin
            if (re_r >= sh)
            begin
                item_next.re.rem     = NUM_W'(re_r - sh);
                item_next.re.q[step] = 1'b1;
            end
            if (im_r >= sh)
            begin
                item_next.im.rem     = NUM_W'(im_r - sh);
                item_next.im.q[step] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/cau_sat.sv
// Output stage: scaling, saturation and status of the complex arithmetic unit.
// Depends on cau_pkg.
module cau_sat (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  cau_pkg::item_t                       in_item,
    output logic                                 out_valid,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] out_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] out_imag,
    output logic [1:0]                           status
);
    import cau_pkg::*;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] re_reg, re_next, im_reg, im_next;
    status_t               st_reg, st_next;
    clamp_t                re_c, im_c;

    always_comb
    begin
        re_c = clamp_mag(in_item.re.neg, in_item.re.mag, 1'b0);
        im_c = clamp_mag(in_item.im.neg, in_item.im.mag, 1'b0);
        unique case (in_item.action)
            ACT_MUL:
            begin
                re_c = clamp_mag(in_item.re.neg, in_item.re.mag >> FRAC_BITS, 1'b0);
                im_c = clamp_mag(in_item.im.neg, in_item.im.mag >> FRAC_BITS, 1'b0);
            end
            ACT_DIV:
            begin
                re_c = clamp_mag(in_item.re.neg, MAG_W'(in_item.re.q), in_item.re.ovf);
                im_c = clamp_mag(in_item.im.neg, MAG_W'(in_item.im.q), in_item.im.ovf);
            end
            default:
            begin
            end
        endcase
        if (in_item.action == ACT_DIV && in_item.den == '0)
        begin
            re_next = '0;
            im_next = '0;
            st_next = ST_DIVZERO;
        end
        else
        begin
            re_next = re_c.val;
            im_next = im_c.val;
            st_next = (re_c.sat || im_c.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_real  = re_reg;
    assign out_imag  = im_reg;
    assign status    = st_reg;

endmodule

// File: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide on Q8.8 operands.
// The pipeline has 3 front-end stages, 17 divider stages and 1 output stage.
// Throughput is one transaction per cycle; the whole pipeline holds on a stall.
// Reset clears only the valid bits; no clearing pass is needed.
// Depends on cau_pkg, cau_prod, cau_div_step, cau_sat and the assertion header.
module complex_arithmetic_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           action,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] left_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] left_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] right_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] right_imag,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] out_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] out_imag,
    output logic [1:0]                           status
);
    import cau_pkg::*;
    `include "complex_arithmetic_unit_assert.svh"

    logic  advance;
    logic  valid_chain [Q_W+1];
    item_t item_chain [Q_W+1];

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    cau_prod u_prod (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (in_valid),
        .action     (action),
        .left_real  (left_real),
        .left_imag  (left_imag),
        .right_real (right_real),
        .right_imag (right_imag),
        .out_valid  (valid_chain[0]),
        .out_item   (item_chain[0])
    );

    for (genvar g = 0; g < Q_W; g++)
    begin : g_div
        cau_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .step      (STEP_W'(Q_W - 1 - g)),
            .in_valid  (valid_chain[g]),
            .in_item   (item_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_item  (item_chain[g+1])
        );
    end

    cau_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (valid_chain[Q_W]),
        .in_item   (item_chain[Q_W]),
        .out_valid (out_valid),
        .out_real  (out_real),
        .out_imag  (out_imag),
        .status    (status)
    );

    `CAU_ASSERT_NOW(a_divzero_zero, out_valid && status == ST_DIVZERO,
        out_real == '0 && out_imag == '0)
    `CAU_ASSERT_NOW(a_sat_bound, out_valid && status == ST_SAT,
        out_real == DATA_WIDTH'(POS_LIM) || out_real == DATA_WIDTH'(NEG_LIM) ||
        out_imag == DATA_WIDTH'(POS_LIM) || out_imag == DATA_WIDTH'(NEG_LIM))
    `CAU_ASSERT_NEXT(a_stall_holds, in_stall, out_valid)

endmodule
